[sv/bresenham_line_pixel_generator_pkg.sv]
package blpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
  } line_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic                          pixel_valid;
    logic                          last_pixel;
  } pixel_t;

endpackage

[sv/bresenham_line_pixel_generator_top.sv]
// Bresenham line rasterizer. A start request (op = start) carries two signed
// endpoints and returns the first pixel of the line; each step request
// returns the next pixel, with last_pixel set on the final one. Step
// requests after the end of a line, or before any start, return a result
// with pixel_valid low and zero coordinates. Exactly one result comes back
// for every request, in order. One request is taken per clock cycle while
// results are taken as fast as they come. A request is held in the input
// register; its result is computed from it and loaded into the result
// register, where it is held until taken. A stalled output holds the
// result register and, with the input register full, holds off the input.
// The start setup (axis differences, steepness compare, endpoint ordering
// and the first error update) is the longest path and sets the clock rate.
module bresenham_line_pixel_generator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  blpg_pkg::line_req_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output blpg_pkg::pixel_t    out_data
);

  localparam int CW = blpg_pkg::COORD_BITS;
  localparam int DW = blpg_pkg::DELTA_BITS;
  localparam int EW = blpg_pkg::ERR_BITS;

  logic                req_valid_r;
  blpg_pkg::line_req_t req_r;
  logic                out_valid_r;
  blpg_pkg::pixel_t    out_data_r;

  logic                line_active_r, line_active_nxt;
  logic                steep_r, steep_nxt;
  logic [CW-1:0]       major_pos_r, major_pos_nxt;
  logic [CW-1:0]       minor_pos_r, minor_pos_nxt;
  logic [CW-1:0]       major_end_r, major_end_nxt;
  logic [DW-1:0]       major_delta_r, major_delta_nxt;
  logic [DW-1:0]       minor_delta_r, minor_delta_nxt;
  logic [EW-1:0]       error_r, error_nxt;
  logic                minor_down_r, minor_down_nxt;
  blpg_pkg::pixel_t    pixel_nxt;

  logic                advance;
  logic                proc_fire;

  logic [DW-1:0]       dx, dy, adx, ady;
  logic                s_steep, s_swap;
  logic [CW-1:0]       a_maj, a_min, b_maj, b_min;
  logic [CW-1:0]       o_maj, o_min, o_maj_end, o_min_end;
  logic [DW-1:0]       s_major_delta, s_dmin, s_minor_delta;
  logic                s_minor_down;

  logic                is_start;
  logic                cur_steep, cur_down, cur_last;
  logic [CW-1:0]       cur_major, cur_minor, cur_end;
  logic [DW-1:0]       cur_md, cur_mind;
  logic [EW-1:0]       cur_err, err_sub, err_add;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !req_valid_r || advance;
  assign proc_fire = req_valid_r && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    dx = {req_r.end_x[CW-1], req_r.end_x} - {req_r.start_x[CW-1], req_r.start_x};
    dy = {req_r.end_y[CW-1], req_r.end_y} - {req_r.start_y[CW-1], req_r.start_y};
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;
    s_steep = ady > adx;
    if (s_steep) begin
      a_maj = req_r.start_y;
      a_min = req_r.start_x;
      b_maj = req_r.end_y;
      b_min = req_r.end_x;
    end else begin
      a_maj = req_r.start_x;
      a_min = req_r.start_y;
      b_maj = req_r.end_x;
      b_min = req_r.end_y;
    end
    s_swap = $signed(a_maj) > $signed(b_maj);
    o_maj     = s_swap ? b_maj : a_maj;
    o_min     = s_swap ? b_min : a_min;
    o_maj_end = s_swap ? a_maj : b_maj;
    o_min_end = s_swap ? a_min : b_min;
    s_major_delta = {o_maj_end[CW-1], o_maj_end} - {o_maj[CW-1], o_maj};
    s_dmin        = {o_min_end[CW-1], o_min_end} - {o_min[CW-1], o_min};
    s_minor_delta = s_dmin[DW-1] ? -s_dmin : s_dmin;
    s_minor_down  = !($signed(o_min) < $signed(o_min_end));
  end

  always_comb begin
    is_start  = (req_r.op == blpg_pkg::OP_START);
    cur_steep = is_start ? s_steep : steep_r;
    cur_major = is_start ? o_maj : major_pos_r;
    cur_minor = is_start ? o_min : minor_pos_r;
    cur_end   = is_start ? o_maj_end : major_end_r;
    cur_md    = is_start ? s_major_delta : major_delta_r;
    cur_mind  = is_start ? s_minor_delta : minor_delta_r;
    cur_err   = is_start ? {2'b00, s_major_delta[DW-1:1]} : error_r;
    cur_down  = is_start ? s_minor_down : minor_down_r;
    cur_last  = (cur_major == cur_end);
    err_sub   = cur_err - {1'b0, cur_mind};
    err_add   = err_sub + {1'b0, cur_md};

    line_active_nxt = line_active_r;
    steep_nxt       = steep_r;
    major_pos_nxt   = major_pos_r;
    minor_pos_nxt   = minor_pos_r;
    major_end_nxt   = major_end_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    error_nxt       = error_r;
    minor_down_nxt  = minor_down_r;
    pixel_nxt       = '0;

    if (is_start || line_active_r) begin
      steep_nxt       = cur_steep;
      major_end_nxt   = cur_end;
      major_delta_nxt = cur_md;
      minor_delta_nxt = cur_mind;
      minor_down_nxt  = cur_down;
      major_pos_nxt   = cur_major;
      minor_pos_nxt   = cur_minor;
      error_nxt       = cur_err;
      pixel_nxt.pixel_x     = cur_steep ? cur_minor : cur_major;
      pixel_nxt.pixel_y     = cur_steep ? cur_major : cur_minor;
      pixel_nxt.pixel_valid = 1'b1;
      pixel_nxt.last_pixel  = cur_last;
      line_active_nxt       = !cur_last;
      if (!cur_last) begin
        major_pos_nxt = cur_major + CW'(1);
        if (err_sub[EW-1]) begin
          minor_pos_nxt = cur_down ? cur_minor - CW'(1) : cur_minor + CW'(1);
          error_nxt     = err_add;
        end else begin
          error_nxt = err_sub;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      line_active_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= req_valid_r;
      end
      if (proc_fire) begin
        line_active_r <= line_active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
    if (proc_fire) begin
      out_data_r    <= pixel_nxt;
      steep_r       <= steep_nxt;
      major_pos_r   <= major_pos_nxt;
      minor_pos_r   <= minor_pos_nxt;
      major_end_r   <= major_end_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      error_r       <= error_nxt;
      minor_down_r  <= minor_down_nxt;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.pixel_valid |->
      out_data_r.pixel_x == '0 && out_data_r.pixel_y == '0 && !out_data_r.last_pixel)
    else $error("invalid result carries nonzero fields");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && pixel_nxt.last_pixel |=> !line_active_r)
    else $error("line still active after last pixel");

  a_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    line_active_r |-> !error_r[EW-1])
    else $error("error term negative on active line");

  a_major_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_active_r |-> $signed(major_pos_r) <= $signed(major_end_r))
    else $error("major position past line end");

endmodule
